>>> sv/i2cbs_pkg.sv
// i2cbs_pkg: command codes, step counts and the pin action record shared by the
// I2C master bit sequencer and its step decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cbs_pkg;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_RECV  = 3'd4,
    CMD_SACK  = 3'd5,
    CMD_RACK  = 3'd6
  } cmd_t;

  localparam logic [7:0]  MSB_MASK        = 8'h80;
  localparam logic [15:0] STEP_TICKS_RST  = 16'd5;

  // Pin writes and samples for the first tick of one step
  typedef struct packed {
    logic       scl_we;
    logic       scl_val;
    logic       sda_we;
    logic       sda_val;
    logic       shift_we;
    logic [7:0] shift_val;
    logic       ack_we;
    logic       ack_val;
  } act_t;

  function automatic logic [4:0] steps_of(input logic [2:0] c);
    logic [4:0] n;
    unique case (c)
      CMD_START: n = 5'd4;
      CMD_STOP:  n = 5'd3;
      CMD_SEND:  n = 5'd24;
      CMD_RECV:  n = 5'd25;
      CMD_SACK:  n = 5'd3;
      CMD_RACK:  n = 5'd4;
      default:   n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> sv/i2cbs_step_decode.sv
// i2cbs_step_decode: pin action of the current step of the active command.
// Depends on i2cbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_step_decode
  import i2cbs_pkg::*;
(
  input  var cmd_t       cmd,
  input  wire  [4:0]     step,
  input  wire  [1:0]     phase,     // step within a bit (send/receive): data/SCL high, SCL high/sample, SCL low
  input  wire  [2:0]     bit_idx,   // bit position, MSB first
  input  wire  [7:0]     shift_byte,
  input  wire            ack_out,
  input  wire            sda_in,
  output act_t           act
);

  logic [7:0] bit_mask;

  assign bit_mask = MSB_MASK >> bit_idx;

  always_comb begin
    act = '0;
    unique case (cmd)
      CMD_START: begin
        unique case (step[1:0])
          2'd0:    begin act.scl_we = 1'b1; act.scl_val = 1'b1; end
          2'd1:    begin act.sda_we = 1'b1; act.sda_val = 1'b1; end
          2'd2:    begin act.sda_we = 1'b1; act.sda_val = 1'b0; end
          default: begin act.scl_we = 1'b1; act.scl_val = 1'b0; end
        endcase
      end
      CMD_STOP: begin
        priority if (step == 5'd0) begin
          act.sda_we = 1'b1; act.sda_val = 1'b0;
        end else if (step == 5'd1) begin
          act.scl_we = 1'b1; act.scl_val = 1'b1;
        end else begin
          act.sda_we = 1'b1; act.sda_val = 1'b1;
        end
      end
      CMD_SEND: begin
        priority if (phase == 2'd0) begin
          act.sda_we = 1'b1; act.sda_val = |(shift_byte & bit_mask);
        end else if (phase == 2'd1) begin
          act.scl_we = 1'b1; act.scl_val = 1'b1;
        end else begin
          act.scl_we = 1'b1; act.scl_val = 1'b0;
        end
      end
      CMD_RECV: begin
        priority if (step == 5'd0) begin
          act.sda_we = 1'b1; act.sda_val = 1'b1;
        end else if (phase == 2'd0) begin
          act.scl_we = 1'b1; act.scl_val = 1'b1;
        end else if (phase == 2'd1) begin
          act.shift_we  = sda_in;
          act.shift_val = shift_byte | bit_mask;
        end else begin
          act.scl_we = 1'b1; act.scl_val = 1'b0;
        end
      end
      CMD_SACK: begin
        priority if (step == 5'd0) begin
          act.sda_we = 1'b1; act.sda_val = ack_out;
        end else if (step == 5'd1) begin
          act.scl_we = 1'b1; act.scl_val = 1'b1;
        end else begin
          act.scl_we = 1'b1; act.scl_val = 1'b0;
        end
      end
      CMD_RACK: begin
        unique case (step[1:0])
          2'd0:    begin act.sda_we = 1'b1; act.sda_val = 1'b1; end
          2'd1:    begin act.scl_we = 1'b1; act.scl_val = 1'b1; end
          2'd2:    begin act.ack_we = 1'b1; act.ack_val = sda_in; end
          default: begin act.scl_we = 1'b1; act.scl_val = 1'b0; end
        endcase
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/i2c_master_bit_sequencer.sv
// Each accepted word's result is registered in the result register, or in the skid register while that one waits.
// Throughput: one word per cycle while in_tready is high; each word is one tick, so the whole state
// update (step decode, tick counter, step counter) closes in that cycle.
// A two-entry output (result register plus skid register) keeps accepting
// while a result waits; in_tready drops only when both are full.
// Reset (rst_n low, synchronous): idle, SCL and SDA released, step_ticks = 5.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_sequencer
  import i2cbs_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  // input words
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [7:0] tx_data, [8] ack_level, [9] sda_in, rest zero
  input  wire  [2:0]  in_tuser,   // [2:0] cmd
  // result words
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [0] scl_level, [1] sda_level, [2] busy_res,
                                  // [3] done_res, [11:4] rx_data, [12] ack_seen
  // step_ticks register
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [15:0] cfg_data
);

  // ---------------------------------------------------------------- config
  logic [15:0] step_ticks_r;
  logic [15:0] step_len;

  assign cfg_ready = 1'b1;
  // zero length behaves as one tick
  assign step_len  = (step_ticks_r == 16'd0) ? 16'd1 : step_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ticks_r <= STEP_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      step_ticks_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------------- state
  cmd_t       act_cmd_r,  act_cmd_nxt;
  logic [4:0] step_r,     step_nxt;
  logic [1:0] phase_r,    phase_nxt;
  logic [2:0] bit_r,      bit_nxt;
  logic [15:0] tick_r,    tick_nxt;
  logic [7:0] shift_r,    shift_nxt;
  logic [7:0] rx_r,       rx_nxt;
  logic       ack_bit_r,  ack_bit_nxt;
  logic       scl_r,      scl_nxt;
  logic       sda_r,      sda_nxt;
  logic       ack_out_r,  ack_out_nxt;

  logic        accept;
  logic [2:0]  in_cmd;
  logic        start;
  cmd_t        eff_cmd;
  logic [4:0]  eff_step;
  logic [1:0]  eff_phase;
  logic [2:0]  eff_bit;
  logic [15:0] eff_tick;
  logic [7:0]  eff_shift;
  logic        eff_ack_out;
  logic [15:0] tick_inc;
  logic        step_end;
  logic [4:0]  step_inc;
  logic        done;
  act_t        act;
  logic        shift_after;
  logic [7:0]  shift_cur;

  assign accept = in_tvalid && in_tready;
  assign in_cmd = in_tuser;
  // a new command only when idle; tick-only and the unused code never start
  assign start  = (act_cmd_r == CMD_TICK) && (in_cmd != CMD_TICK) && (steps_of(in_cmd) != 5'd0);

  always_comb begin
    eff_cmd     = start ? cmd_t'(in_cmd) : act_cmd_r;
    eff_step    = start ? 5'd0  : step_r;
    eff_phase   = start ? 2'd0  : phase_r;
    eff_bit     = start ? 3'd0  : bit_r;
    eff_tick    = start ? 16'd0 : tick_r;
    eff_shift   = shift_r;
    eff_ack_out = ack_out_r;
    if (start && (in_cmd == CMD_SEND)) eff_shift = in_tdata[7:0];
    if (start && (in_cmd == CMD_RECV)) eff_shift = 8'd0;
    if (start && (in_cmd == CMD_SACK)) eff_ack_out = in_tdata[8];
  end

  i2cbs_step_decode u_dec (
    .cmd        (eff_cmd),
    .step       (eff_step),
    .phase      (eff_phase),
    .bit_idx    (eff_bit),
    .shift_byte (eff_shift),
    .ack_out    (eff_ack_out),
    .sda_in     (in_tdata[9]),
    .act        (act)
  );

  assign tick_inc    = eff_tick + 16'd1;
  // counter wrap also ends the step
  assign step_end    = (tick_inc >= step_len) || (tick_inc == 16'd0);
  assign step_inc    = eff_step + 5'd1;
  assign shift_after = (eff_tick == 16'd0) && act.shift_we;
  assign shift_cur   = shift_after ? act.shift_val : eff_shift;

  always_comb begin
    act_cmd_nxt = eff_cmd;
    step_nxt    = eff_step;
    phase_nxt   = eff_phase;
    bit_nxt     = eff_bit;
    tick_nxt    = eff_tick;
    shift_nxt   = shift_cur;
    rx_nxt      = rx_r;
    ack_bit_nxt = ack_bit_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    ack_out_nxt = eff_ack_out;
    done        = 1'b0;
    if (eff_cmd != CMD_TICK) begin
      // pin action on the first tick of a step
      if (eff_tick == 16'd0) begin
        if (act.scl_we) scl_nxt     = act.scl_val;
        if (act.sda_we) sda_nxt     = act.sda_val;
        if (act.ack_we) ack_bit_nxt = act.ack_val;
      end
      if (step_end) begin
        tick_nxt = 16'd0;
        step_nxt = step_inc;
        // receive byte: the SDA release step sits before the bit phases
        if (!((eff_cmd == CMD_RECV) && (eff_step == 5'd0))) begin
          if (eff_phase == 2'd2) begin
            phase_nxt = 2'd0;
            bit_nxt   = eff_bit + 3'd1;
          end else begin
            phase_nxt = eff_phase + 2'd1;
          end
        end
        if (step_inc >= steps_of(eff_cmd)) begin
          if (eff_cmd == CMD_RECV) rx_nxt = shift_cur;
          act_cmd_nxt = CMD_TICK;
          step_nxt    = 5'd0;
          done        = 1'b1;
        end
      end else begin
        tick_nxt = tick_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_cmd_r <= CMD_TICK;
      step_r    <= 5'd0;
      phase_r   <= 2'd0;
      bit_r     <= 3'd0;
      tick_r    <= 16'd0;
      shift_r   <= 8'd0;
      rx_r      <= 8'd0;
      ack_bit_r <= 1'b0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      ack_out_r <= 1'b0;
    end else if (accept) begin
      act_cmd_r <= act_cmd_nxt;
      step_r    <= step_nxt;
      phase_r   <= phase_nxt;
      bit_r     <= bit_nxt;
      tick_r    <= tick_nxt;
      shift_r   <= shift_nxt;
      rx_r      <= rx_nxt;
      ack_bit_r <= ack_bit_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      ack_out_r <= ack_out_nxt;
    end
  end

  // ---------------------------------------------------------------- result
  logic [15:0] res_word;
  logic        res_busy;

  assign res_busy = (act_cmd_nxt != CMD_TICK);
  assign res_word = {3'b000, ack_bit_nxt, rx_nxt, done, res_busy, sda_nxt, scl_nxt};

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r,  out_data_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic [15:0] skid_data_r,  skid_data_nxt;
  logic        pop;

  assign pop       = out_valid_r && out_tready;
  assign in_tready = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_word;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res_word;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while result register empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready && accept))
    else $error("skid filled without a stalled result");

  a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (act_cmd_r == CMD_TICK) |-> (step_r == 5'd0 && tick_r == 16'd0))
    else $error("idle with step or tick counter not cleared");

  a_tick_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (act_cmd_r != CMD_TICK) |-> (tick_r < step_len))
    else $error("tick counter beyond step length");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && done |=> (act_cmd_r == CMD_TICK))
    else $error("command still active after done");
`endif

endmodule

`default_nettype wire
